// File: rtl/smbf_pkg.sv
package smbf_pkg;

    // Register and state widths
    localparam int unsigned GL_W        = 7;
    localparam int unsigned POS_W       = 6;
    localparam logic [GL_W-1:0] GROUP_MAX   = 7'd64;
    localparam logic [GL_W-1:0] GROUP_RESET = 7'd12;
    localparam logic [GL_W-1:0] GROUP_MIN   = 7'd1;

    // Framing bytes sent on reads
    localparam logic [7:0] STX_CODE  = 8'h02;
    localparam logic [7:0] ETX_CODE  = 8'h03;
    localparam logic [7:0] FILL_CODE = 8'h00;

    // Stream widths
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // Serializer steps: 0..7 carry bits, 8 is the chip-select release
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_BIT_STEP = 4'd7;
    localparam logic [STEP_W-1:0] PAUSE_STEP    = 4'd8;
    localparam logic [2:0]        BIT_TOP       = 3'd7;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [7:0] send_byte;
        logic [7:0] rx_src;
        logic       do_pause;
    } job_t;

endpackage

// File: rtl/smbf_front.sv
module smbf_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [smbf_pkg::GL_W-1:0]    cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [smbf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tuser,
    input  logic                         q_full,
    output logic                         q_push,
    output smbf_pkg::job_t               q_job
);
    import smbf_pkg::*;

    logic [GL_W-1:0]  group_length_reg;
    logic [POS_W-1:0] group_pos_reg, group_pos_next;
    logic             msg_start_reg, msg_start_next;

    logic [GL_W-1:0]  gl_eff;
    logic [GL_W-1:0]  gl_m1_full;
    logic [POS_W-1:0] gl_m1;
    logic             is_read;
    logic [7:0]       tx_byte;
    logic [7:0]       miso_bits;
    logic             accept;

    assign tx_byte   = s_tdata[7:0];
    assign miso_bits = s_tdata[15:8];
    assign is_read   = (cmd_t'(s_tuser) == CMD_READ);
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign q_push    = accept;

    // Clamp the group length into its legal range
    always_comb begin
        if (group_length_reg == '0) begin
            gl_eff = GROUP_MIN;
        end else if (group_length_reg > GROUP_MAX) begin
            gl_eff = GROUP_MAX;
        end else begin
            gl_eff = group_length_reg;
        end
        gl_m1_full = gl_eff - GROUP_MIN;
        gl_m1      = gl_m1_full[POS_W-1:0];
    end

    // Classify the word: pick the byte to send and decide on a pause
    always_comb begin
        if (is_read) begin
            if (msg_start_reg) begin
                q_job.send_byte = STX_CODE;
            end else if (s_tlast) begin
                q_job.send_byte = ETX_CODE;
            end else begin
                q_job.send_byte = FILL_CODE;
            end
            q_job.rx_src = miso_bits;
        end else begin
            q_job.send_byte = tx_byte;
            q_job.rx_src    = '0;
        end
        q_job.do_pause = !s_tlast && (group_pos_reg >= gl_m1);
    end

    // Advance the group count and message-start flag per accepted word
    always_comb begin
        group_pos_next = group_pos_reg;
        msg_start_next = msg_start_reg;
        if (accept) begin
            if (s_tlast || q_job.do_pause) begin
                group_pos_next = '0;
            end else begin
                group_pos_next = group_pos_reg + POS_W'(1);
            end
            msg_start_next = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_length_reg <= GROUP_RESET;
            group_pos_reg    <= '0;
            msg_start_reg    <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                group_length_reg <= cfg_wr_data;
            end
            group_pos_reg <= group_pos_next;
            msg_start_reg <= msg_start_next;
        end
    end

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (group_pos_reg == '0) && msg_start_reg)
        else $error("last byte did not restart the message");

    a_pause_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && q_job.do_pause) |=> (group_pos_reg == '0) && !msg_start_reg)
        else $error("pause did not restart the group");

    a_pause_never_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |-> !q_job.do_pause)
        else $error("pause scheduled after last byte");

endmodule

// File: rtl/smbf_queue.sv
module smbf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  smbf_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output smbf_pkg::job_t head,
    output logic           empty
);
    import smbf_pkg::*;

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// File: rtl/smbf_back.sv
module smbf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  smbf_pkg::job_t                head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smbf_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import smbf_pkg::*;

    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;
    logic                m_pause_reg;

    logic                out_free;
    logic                emit;
    logic                is_pause_step;
    logic                final_step;
    logic [2:0]          bit_idx;
    logic [7:0]          rx_mask;
    logic                mosi_bit;
    logic                chip_select_n;
    logic [7:0]          rx_byte;
    logic [M_DATA_W-1:0] data_word;

    assign out_free      = !m_valid_reg || m_tready;
    assign emit          = out_free && !q_empty;
    assign is_pause_step = (step_reg == PAUSE_STEP);
    assign final_step    = is_pause_step || ((step_reg == LAST_BIT_STEP) && !head.do_pause);
    assign q_pop         = emit && final_step;

    // Build one result: a serial bit, or the chip-select release
    always_comb begin
        bit_idx = BIT_TOP - step_reg[2:0];
        if (is_pause_step) begin
            rx_mask       = 8'hFF;
            mosi_bit      = 1'b0;
            chip_select_n = 1'b1;
        end else begin
            rx_mask       = 8'hFF << bit_idx;
            mosi_bit      = head.send_byte[bit_idx];
            chip_select_n = 1'b0;
        end
        rx_byte   = head.rx_src & rx_mask;
        data_word = {{(M_DATA_W - 10){1'b0}}, rx_byte, chip_select_n, mosi_bit};
    end

    // Step through the job and track the output register
    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            step_next    = final_step ? '0 : step_reg + STEP_W'(1);
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg  <= data_word;
            m_last_reg  <= final_step;
            m_pause_reg <= is_pause_step;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_pause_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= PAUSE_STEP)
        else $error("serializer step out of range");

    a_pause_step_needs_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_pause_step && !q_empty) |-> head.do_pause)
        else $error("pause step reached on a job without pause");

    a_step_holds_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !emit |=> $stable(step_reg))
        else $error("serializer step moved without emitting");

endmodule

// File: rtl/spi_mcu_link_byte_framer_top.sv
// SPI master byte framer for a microcontroller link.
// Input stream: one word per byte. s_tuser is the command (0 write, 1 read),
// s_tlast marks the last byte of a message, s_tdata holds tx_byte and the
// eight MISO samples for that byte (first sample in bit 15).
// Output stream: one word per serial bit clock, MSB first. m_tuser flags the
// chip-select release that follows every group_length bytes of a message
// (never after its last byte); m_tlast marks the final word of each byte.
// Configuration: cfg_wr_en writes group_length (1..64, reset 12); write it
// only while the block is idle.
// Path: a taken byte is written into the job queue, then its first output word is registered.
// Throughput: eight words per byte, nine when a chip-select release is due; the
// serializer emits one word per cycle while the receiver is ready. A two-entry job
// queue lets new bytes be taken while the serializer is busy.
// Reset: group count cleared, the next byte starts a message, group_length 12,
// queue and output register empty.
// Receiver stall: the output word holds; the serializer waits, and once the
// queue fills s_tready drops.
module spi_mcu_link_byte_framer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [smbf_pkg::GL_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] tx_byte, [15:8] miso_bits
    input  logic [smbf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    // [0] command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] mosi_bit, [1] chip_select_n, [9:2] rx_byte, [15:10] zero
    output logic [smbf_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    // [0] pause
    output logic                          m_tuser
);
    import smbf_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t push_job;
    job_t head_job;

    smbf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    smbf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty)
    );

    smbf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: dv/spi_mcu_link_byte_framer_top_tb.sv
`timescale 1ns / 1ps

module spi_mcu_link_byte_framer_top_tb;

    import smbf_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 1000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned NUM_DIR_ROWS    = 20;
    localparam int unsigned NUM_PHASES      = 8;

    // One serial clock (or chip-select release) as seen on the result stream
    typedef struct packed {
        logic       mosi;
        logic       csn;
        logic       pause;
        logic [7:0] rx;
        logic       last;
    } link_word_t;

    // Directed byte; when pinned, the sent byte and pause flag are typed in
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx;
        logic       last;
        logic [7:0] miso;
        logic       pinned;
        logic [7:0] pin_send;
        logic       pin_pause;
    } byte_row_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [GL_W-1:0]       cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // Mirror of the framer state
    logic [GL_W-1:0]       grp_len_reg = GROUP_RESET;
    logic [POS_W-1:0]      grp_pos     = '0;
    logic                  msg_first   = 1'b1;

    link_word_t            link_words_q[$];
    int unsigned           mismatches  = 0;
    int unsigned           msg_left    = 0;
    int unsigned           gap_pct     = 0;
    int unsigned           stall_pct   = 0;
    int unsigned           stall_left  = 0;
    int unsigned           idle_cycles = 0;
    logic                  quiet       = 1'b0;

    byte_row_t dir_tab [NUM_DIR_ROWS] = '{
        // fresh after reset: read sends STX
        '{CMD_READ,  8'h00, 1'b0, 8'hFF, 1'b1, STX_CODE,  1'b0},
        '{CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 8'hFF,     1'b0},
        '{CMD_WRITE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'h00,     1'b0},
        // mid-message read sends fill, tx ignored
        '{CMD_READ,  8'h5C, 1'b0, 8'hA5, 1'b1, FILL_CODE, 1'b0},
        '{CMD_READ,  8'h00, 1'b1, 8'h5A, 1'b1, ETX_CODE,  1'b0},
        // first and last at once: STX wins
        '{CMD_READ,  8'hFF, 1'b1, 8'h80, 1'b1, STX_CODE,  1'b0},
        '{CMD_WRITE, 8'h80, 1'b1, 8'h01, 1'b1, 8'h80,     1'b0},
        // twelve-byte group at the reset group length, mixed commands
        '{CMD_WRITE, 8'h01, 1'b0, 8'h7E, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'h7E, 1'b0, 8'hC3, 1'b0, 8'h00,     1'b0},
        '{CMD_READ,  8'hC3, 1'b0, 8'h3C, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'h3C, 1'b0, 8'h96, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'hAA, 1'b0, 8'h55, 1'b0, 8'h00,     1'b0},
        '{CMD_READ,  8'h55, 1'b0, 8'hAA, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'h0F, 1'b0, 8'hF0, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'hF0, 1'b0, 8'h0F, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'h69, 1'b0, 8'h12, 1'b0, 8'h00,     1'b0},
        '{CMD_READ,  8'h12, 1'b0, 8'h69, 1'b0, 8'h00,     1'b0},
        '{CMD_WRITE, 8'hE7, 1'b0, 8'h18, 1'b0, 8'h00,     1'b0},
        // twelfth byte of the group: chip-select release follows
        '{CMD_WRITE, 8'h01, 1'b0, 8'hFE, 1'b1, 8'h01,     1'b1},
        // last byte right after a release: ETX, no release
        '{CMD_READ,  8'h00, 1'b1, 8'h7F, 1'b1, ETX_CODE,  1'b0}
    };

    logic [GL_W-1:0] phase_group [NUM_PHASES] = '{7'd1, 7'd0, 7'd64, 7'd3,
                                                  7'd127, 7'd2, 7'd12, 7'd13};
    int unsigned     phase_items [NUM_PHASES] = '{12, 12, 60, 12, 60, 12, 12, 20};

    spi_mcu_link_byte_framer_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp the register the way the framer does
    function automatic logic [GL_W-1:0] eff_group();
        if (grp_len_reg == '0) begin
            return GROUP_MIN;
        end
        if (grp_len_reg > GROUP_MAX) begin
            return GROUP_MAX;
        end
        return grp_len_reg;
    endfunction

    // Work out the byte on MOSI and whether a release is due; advance the group
    function automatic void predict_byte(input cmd_t cmd, input logic [7:0] tx,
                                         input logic last, output logic [7:0] send,
                                         output logic pause_due);
        logic [GL_W-1:0] grp;
        grp = eff_group();
        if (cmd == CMD_READ) begin
            send = msg_first ? STX_CODE : (last ? ETX_CODE : FILL_CODE);
        end else begin
            send = tx;
        end
        pause_due = !last && ({1'b0, grp_pos} >= grp - GROUP_MIN);
        grp_pos   = (last || pause_due) ? '0 : grp_pos + POS_W'(1);
        msg_first = last;
    endfunction

    // Queue the eight bit words, plus the release word when due
    function automatic void push_link_words(input logic [7:0] send, input logic is_rd,
                                            input logic [7:0] miso, input logic pause_due);
        link_word_t w;
        logic [7:0] rx_acc;
        int         b;
        rx_acc = '0;
        for (b = 7; b >= 0; b--) begin
            if (is_rd) begin
                rx_acc[b] = miso[b];
            end
            w.mosi  = send[b];
            w.csn   = 1'b0;
            w.pause = 1'b0;
            w.rx    = rx_acc;
            w.last  = (b == 0) && !pause_due;
            link_words_q.push_back(w);
        end
        if (pause_due) begin
            w.mosi  = 1'b0;
            w.csn   = 1'b1;
            w.pause = 1'b1;
            w.rx    = rx_acc;
            w.last  = 1'b1;
            link_words_q.push_back(w);
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Present one byte, hold it until taken, then queue its expected words
    task automatic send_byte(input byte_row_t row);
        logic [7:0] send;
        logic       pause_due;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tlast  <= row.last;
        s_tdata  <= {row.miso, row.tx};
        do @(posedge aclk); while (!s_tready);
        predict_byte(row.cmd, row.tx, row.last, send, pause_due);
        if (row.pinned) begin
            push_link_words(row.pin_send, row.cmd == CMD_READ, row.miso, row.pin_pause);
        end else begin
            push_link_words(send, row.cmd == CMD_READ, row.miso, pause_due);
        end
    endtask

    // Drain, then write the group length while the link is idle
    task automatic write_group(input logic [GL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (link_words_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grp_len_reg = value;
    endtask

    // Mostly well-formed messages with random content, some stray bytes
    task automatic send_random(input int unsigned count);
        byte_row_t   row;
        int unsigned grp;
        int unsigned i;
        for (i = 0; i < count; i++) begin
            grp = 32'(eff_group());
            row.cmd    = cmd_t'($urandom_range(0, 1));
            row.tx     = 8'($urandom_range(0, 255));
            row.miso   = 8'($urandom_range(0, 255));
            row.pinned = 1'b0;
            row.pin_send  = '0;
            row.pin_pause = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                row.last = 1'($urandom_range(0, 1));
                if (row.last) begin
                    msg_left = 0;
                end
            end else begin
                if (msg_left == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        msg_left = 1;
                    end else if ($urandom_range(0, 1) == 0) begin
                        msg_left = $urandom_range(grp, grp + 4);
                    end else begin
                        msg_left = $urandom_range(1, 3 * grp);
                    end
                end
                msg_left--;
                row.last = (msg_left == 0);
            end
            send_byte(row);
        end
    endtask

    // Check each result word against the oldest expectation; pace m_tready
    always @(posedge aclk) begin
        link_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (link_words_q.size() == 0) begin
                $display("%0t: unexpected word expected none actual %0h", $time, m_tdata);
                mismatches++;
            end else begin
                w = link_words_q.pop_front();
                cmp_field("mosi_bit", 8'(w.mosi), 8'(m_tdata[0]));
                cmp_field("chip_select_n", 8'(w.csn), 8'(m_tdata[1]));
                cmp_field("rx_byte", w.rx, m_tdata[9:2]);
                cmp_field("pad", 8'h00, 8'(m_tdata[15:10]));
                cmp_field("pause", 8'(w.pause), 8'(m_tuser));
                cmp_field("last_result", 8'(w.last), 8'(m_tlast));
            end
        end
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 7) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Abort when neither side moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("spi_mcu_link_byte_framer_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned p;
        int unsigned r;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bytes at the reset group length
        gap_pct   = 30;
        stall_pct = 30;
        for (r = 0; r < NUM_DIR_ROWS; r++) begin
            send_byte(dir_tab[r]);
        end

        // Random phases across group lengths; the last one runs at full rate
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                write_group(phase_group[p]);
                quiet     = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                write_group((p == NUM_PHASES - 2) ? 7'($urandom_range(1, 64))
                                                  : phase_group[p]);
                gap_pct   = $urandom_range(0, 2) * 25;
                stall_pct = $urandom_range(0, 2) * 25;
            end
            send_random(phase_items[p]);
        end

        // Drain and let the pipe settle
        s_tvalid <= 1'b0;
        while (link_words_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && link_words_q.size() == 0) begin
            $display("spi_mcu_link_byte_framer_top: match");
        end else begin
            $display("spi_mcu_link_byte_framer_top: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/smbf_pkg.sv
rtl/smbf_front.sv
rtl/smbf_queue.sv
rtl/smbf_back.sv
rtl/spi_mcu_link_byte_framer_top.sv
dv/spi_mcu_link_byte_framer_top_tb.sv
